>>> sv/ucs_pkg.sv
`timescale 1ns / 1ps

package ucs_pkg;

	localparam logic [15:0] DEFAULT_PORT_RESET = 16'd80;
	localparam logic [15:0] PORT_MAX = 16'hFFFF;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Progress through the word "news"; NEWS_FAIL marks a mismatch.
	localparam logic [2:0] NEWS_FULL = 3'd4;
	localparam logic [2:0] NEWS_FAIL = 3'd7;

	typedef enum logic [3:0] {
		PH_SCHEME_START  = 4'd0,
		PH_SCHEME        = 4'd1,
		PH_AFTER_COLON   = 4'd2,
		PH_SLASH_HELD    = 4'd3,
		PH_HOST_START    = 4'd4,
		PH_LITERAL       = 4'd5,
		PH_AFTER_LITERAL = 4'd6,
		PH_HOST          = 4'd7,
		PH_PORT_START    = 4'd8,
		PH_PORT          = 4'd9,
		PH_PATH          = 4'd10,
		PH_ERROR         = 4'd11
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_EMPTY       = 3'd1,
		ST_INCOMPLETE  = 3'd2,
		ST_BAD_LITERAL = 3'd3,
		ST_BAD_PORT    = 3'd4,
		ST_NEEDS_HOST  = 3'd5,
		ST_BAD_PATH    = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		TAG_SEP    = 3'd0,
		TAG_SCHEME = 3'd1,
		TAG_HOST   = 3'd2,
		TAG_PORT   = 3'd3,
		TAG_PATH   = 3'd4
	} tag_t;

	typedef struct packed {
		logic [7:0]  ch;
		tag_t        tag;
		logic        last;
		logic        done;
		status_t     status;
		logic [15:0] port;
	} ucs_result_t;

	// Results produced by one input byte, in delivery order.
	typedef struct packed {
		logic [1:0]  count;
		ucs_result_t r0;
		ucs_result_t r1;
	} ucs_step_t;

	function automatic logic [7:0] news_char(input logic [1:0] idx);
		case (idx)
			2'd0: news_char = 8'h6E;
			2'd1: news_char = 8'h65;
			2'd2: news_char = 8'h77;
			2'd3: news_char = 8'h73;
			default: news_char = 8'h00;
		endcase
	endfunction

	function automatic status_t keep_first(input status_t cur, input status_t code);
		keep_first = (cur == ST_OK) ? code : cur;
	endfunction

endpackage

>>> sv/ucs_parser.sv
`timescale 1ns / 1ps

module ucs_parser import ucs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  ch,
	input  logic [15:0] default_port,
	output ucs_step_t   step
);

	phase_t      phase_q, ph;
	logic [2:0]  news_q, nm;
	logic [15:0] acc_q, acc;
	logic        given_q, pg;
	status_t     err_q, err;

	ucs_result_t res;
	logic        emit;
	logic        two;
	logic        is_news;
	logic        digit;
	logic [19:0] acc_next;
	logic [1:0]  n;
	ucs_result_t r0, r1;

	assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign acc_next = {4'd0, acc_q} * 20'd10 + {16'd0, ch[3:0]};

	always_comb begin
		ph = phase_q;
		nm = news_q;
		acc = acc_q;
		pg = given_q;
		err = err_q;
		n = 2'd0;
		r0 = '0;
		r1 = '0;
		res = '0;
		emit = 1'b1;
		two = 1'b0;

		// A slash held after the scheme's colon is released ahead of this byte.
		if (phase_q == PH_SLASH_HELD) begin
			r0.ch = CH_SLASH;
			n = 2'd1;
			if (ch == CH_SLASH) begin
				r1.ch = CH_SLASH;
				r1.last = 1'b1;
				n = 2'd2;
				ph = PH_HOST_START;
				two = 1'b1;
			end else if (news_q == NEWS_FULL) begin
				r0.tag = TAG_PATH;
				ph = PH_PATH;
			end else begin
				err = keep_first(err, ST_NEEDS_HOST);
				ph = PH_ERROR;
			end
		end
		is_news = (news_q == NEWS_FULL);

		res.ch = ch;
		res.last = 1'b1;
		res.tag = TAG_SEP;

		if (two) begin
			emit = 1'b0;
		end else if (ch == CH_NUL) begin
			case (ph)
				PH_SCHEME_START: begin
					err = keep_first(err, ST_EMPTY);
				end
				PH_SCHEME, PH_HOST_START, PH_HOST, PH_AFTER_LITERAL: begin
					err = keep_first(err, ST_INCOMPLETE);
				end
				PH_AFTER_COLON: begin
					err = keep_first(err, is_news ? ST_BAD_PATH : ST_NEEDS_HOST);
				end
				PH_LITERAL: begin
					err = keep_first(err, ST_BAD_LITERAL);
				end
				PH_PORT_START: begin
					err = keep_first(err, ST_BAD_PORT);
				end
				PH_PORT: begin
					err = keep_first(err, ST_BAD_PATH);
				end
				default: begin
				end
			endcase
			res.done = 1'b1;
			res.status = err;
			res.port = pg ? acc : default_port;
			ph = PH_SCHEME_START;
			nm = 3'd0;
			acc = 16'd0;
			pg = 1'b0;
			err = ST_OK;
		end else begin
			case (ph)
				PH_SCHEME_START, PH_SCHEME: begin
					ph = PH_SCHEME;
					if (ch == CH_COLON) begin
						ph = PH_AFTER_COLON;
					end else begin
						res.tag = TAG_SCHEME;
						if (news_q < NEWS_FULL && ch == news_char(news_q[1:0])) begin
							nm = news_q + 3'd1;
						end else begin
							nm = NEWS_FAIL;
						end
					end
				end
				PH_AFTER_COLON: begin
					if (ch == CH_SLASH) begin
						ph = PH_SLASH_HELD;
						emit = 1'b0;
					end else begin
						err = keep_first(err, is_news ? ST_BAD_PATH : ST_NEEDS_HOST);
						ph = PH_ERROR;
					end
				end
				PH_HOST_START, PH_HOST: begin
					if (ph == PH_HOST_START && ch == CH_LBRACKET) begin
						res.tag = TAG_HOST;
						ph = PH_LITERAL;
					end else if (ch == CH_SLASH) begin
						res.tag = TAG_PATH;
						ph = PH_PATH;
					end else if (ch == CH_COLON) begin
						ph = PH_PORT_START;
					end else begin
						res.tag = TAG_HOST;
						ph = PH_HOST;
					end
				end
				PH_LITERAL: begin
					if (ch == CH_RBRACKET) begin
						ph = PH_AFTER_LITERAL;
					end else begin
						res.tag = TAG_HOST;
					end
				end
				PH_AFTER_LITERAL: begin
					if (ch == CH_COLON) begin
						ph = PH_PORT_START;
					end else if (ch == CH_SLASH) begin
						res.tag = TAG_PATH;
						ph = PH_PATH;
					end else begin
						err = keep_first(err, ST_BAD_PATH);
						ph = PH_ERROR;
					end
				end
				PH_PORT_START, PH_PORT: begin
					if (digit) begin
						acc = (acc_next > {4'd0, PORT_MAX}) ? PORT_MAX : acc_next[15:0];
						pg = 1'b1;
						res.tag = TAG_PORT;
						ph = PH_PORT;
					end else if (ph == PH_PORT_START) begin
						err = keep_first(err, ST_BAD_PORT);
						ph = PH_ERROR;
					end else if (ch == CH_SLASH) begin
						res.tag = TAG_PATH;
						ph = PH_PATH;
					end else begin
						err = keep_first(err, ST_BAD_PATH);
						ph = PH_ERROR;
					end
				end
				PH_PATH: begin
					res.tag = TAG_PATH;
				end
				default: begin
				end
			endcase
		end

		if (emit) begin
			if (n == 2'd0) begin
				r0 = res;
			end else begin
				r1 = res;
			end
			n = n + 2'd1;
		end
	end

	assign step.count = n;
	assign step.r0 = r0;
	assign step.r1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCHEME_START;
			news_q <= 3'd0;
			acc_q <= 16'd0;
			given_q <= 1'b0;
			err_q <= ST_OK;
		end else if (step_en) begin
			phase_q <= ph;
			news_q <= nm;
			acc_q <= acc;
			given_q <= pg;
			err_q <= err;
		end
	end

endmodule

>>> sv/url_component_splitter_core.sv
`timescale 1ns / 1ps
// Channel     Direction  Handshake                     Contents
// s_axis      in         s_axis_tvalid/s_axis_tready   one URL byte per transaction
// m_axis      out        m_axis_tvalid/m_axis_tready   one classified byte per transaction
// cfg         in         cfg_valid/cfg_ready           default port
//
// A byte is registered on input and classified from that register once the queue has room;
// each result is written to the queue, whose head drives m_axis. One byte is taken every
// cycle while the result queue (four entries) has room for two results; a byte that yields
// two results fills two entries. Reset clears the parser state, the queue and the default
// port (80). A stall on m_axis fills the queue and then holds s_axis_tready low.

module url_component_splitter_core import ucs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] url_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, [26:11] port_number
	output logic [3:0]  m_axis_tuser,   // [2:0] part_tag, [3] url_done
	output logic        m_axis_tlast,   // last_of_item
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data        // default_port
);

	logic [15:0]         default_port_q;
	logic                valid_s1;
	logic [7:0]          ch_s1;
	logic                step_en;
	ucs_step_t           step;
	ucs_result_t         queue_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                pop;
	logic [QUEUE_AW:0]   push_n;
	ucs_result_t         head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_port_q <= DEFAULT_PORT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			default_port_q <= cfg_data;
		end
	end

	// The held byte is classified once the queue can take two results.
	assign step_en = valid_s1 && (count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	ucs_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.ch           (ch_s1),
		.default_port (default_port_q),
		.step         (step)
	);

	assign pop = m_axis_tvalid && m_axis_tready;
	assign push_n = step_en ? {{(QUEUE_AW - 1){1'b0}}, step.count} : '0;

	always_ff @(posedge clk) begin
		if (step_en && step.count != 2'd0) begin
			queue_q[wr_ptr_q] <= step.r0;
		end
		if (step_en && step.count == 2'd2) begin
			queue_q[wr_ptr_q + QUEUE_AW'(1)] <= step.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[QUEUE_AW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			count_q <= count_q + push_n - {{QUEUE_AW{1'b0}}, pop};
		end
	end

	assign head = queue_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata = {5'd0, head.port, head.status, head.ch};
	assign m_axis_tuser = {head.done, head.tag};
	assign m_axis_tlast = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast && m_axis_tdata[7:0] == CH_NUL)
		else $error("terminator transaction malformed");

	a_status_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tdata[26:8] == '0)
		else $error("status or port reported without done");

	a_step_fits: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |-> step.count != 2'd3)
		else $error("parser produced too many results");

endmodule
